// ===== rtl/core/eypr_pkg.sv =====
`default_nettype none
package eypr_pkg;
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int OUT_FRAC_BITS_DEF   = 16;
    localparam int IN_W   = 18;
    localparam int OUT_W  = 18;
    localparam int WORK_BITS = 30;
    localparam int CORDIC_STEPS = 28;
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    // residual angle width: 360*2^12*1e9 < 2^61
    localparam int ZW = 64;
    localparam int XW = 33;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_nd(input logic [4:0] i);
        case (i)
            5'd0:  atan_nd = 64'sd45000000000;
            5'd1:  atan_nd = 64'sd26565051177;
            5'd2:  atan_nd = 64'sd14036243468;
            5'd3:  atan_nd = 64'sd7125016349;
            5'd4:  atan_nd = 64'sd3576334375;
            5'd5:  atan_nd = 64'sd1789910608;
            5'd6:  atan_nd = 64'sd895173710;
            5'd7:  atan_nd = 64'sd447614171;
            5'd8:  atan_nd = 64'sd223810500;
            5'd9:  atan_nd = 64'sd111905677;
            5'd10: atan_nd = 64'sd55952892;
            5'd11: atan_nd = 64'sd27976453;
            5'd12: atan_nd = 64'sd13988227;
            5'd13: atan_nd = 64'sd6994114;
            5'd14: atan_nd = 64'sd3497057;
            5'd15: atan_nd = 64'sd1748528;
            5'd16: atan_nd = 64'sd874264;
            5'd17: atan_nd = 64'sd437132;
            5'd18: atan_nd = 64'sd218566;
            5'd19: atan_nd = 64'sd109283;
            5'd20: atan_nd = 64'sd54642;
            5'd21: atan_nd = 64'sd27321;
            5'd22: atan_nd = 64'sd13660;
            5'd23: atan_nd = 64'sd6830;
            5'd24: atan_nd = 64'sd3415;
            5'd25: atan_nd = 64'sd1708;
            5'd26: atan_nd = 64'sd854;
            5'd27: atan_nd = 64'sd427;
            default: atan_nd = '0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/eypr_cell.sv =====
`default_nettype none
// One CORDIC micro-rotation, registered; shift and atan fixed per cell.
module eypr_cell #(
    parameter int STEP = 0,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  eypr_pkg::cord_t     d_in,
    output eypr_pkg::cord_t     d_out
);
    import eypr_pkg::*;
    localparam logic signed [ZW-1:0] DA = atan_nd(5'(STEP)) <<< ANGLE_FRAC_BITS;
    cord_t nxt;
    logic signed [XW-1:0] dx, dy;
    always_comb begin
        dx = d_in.y >>> STEP;
        dy = d_in.x >>> STEP;
        nxt = d_in;
        if (!d_in.z[ZW-1]) begin
            nxt.x = d_in.x - dx;
            nxt.y = d_in.y + dy;
            nxt.z = d_in.z - DA;
        end else begin
            nxt.x = d_in.x + dx;
            nxt.y = d_in.y - dy;
            nxt.z = d_in.z + DA;
        end
    end
    cord_t d_reg;
    always_ff @(posedge aclk) begin
        if (en) d_reg <= nxt;
    end
    assign d_out = d_reg;
endmodule
`default_nettype wire

// ===== rtl/core/eypr_sincos.sv =====
`default_nettype none
// Range reduction (2 stages) then a chain of CORDIC cells.
module eypr_sincos #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  en,
    input  wire logic signed [eypr_pkg::IN_W-1:0]      ang,
    output logic signed [eypr_pkg::XW-1:0]             sin_q,
    output logic signed [eypr_pkg::XW-1:0]             cos_q
);
    import eypr_pkg::*;
    localparam int UNIT = 1 << ANGLE_FRAC_BITS;
    localparam int TURN = 360 * UNIT;
    localparam int HALF = 180 * UNIT;
    localparam int QUARTER = 90 * UNIT;
    // wide enough for TURN*2^7 at 12 fraction bits
    localparam int MW = 30;
    // input magnitude at most 2^17, turn at least 5760: at most ~23 turns.
    // Binary restoring reduction by TURN*2^k: k = 7..4 before the input
    // register, k = 3..0 plus the fold to (-180, 180] after it.
    logic signed [MW-1:0] a_reg, m1, m_reg;
    logic signed [MW-1:0] t, a_part;
    logic signed [MW-1:0] r;
    always_comb begin
        t = MW'(ang);
        for (int k = 7; k >= 4; k--) begin
            if (t >= MW'(TURN) <<< k) t = t - (MW'(TURN) <<< k);
            else if (t < -(MW'(TURN) <<< k)) t = t + (MW'(TURN) <<< k);
        end
        a_part = t;
    end
    always_comb begin
        r = a_reg;
        for (int k = 3; k >= 0; k--) begin
            if (r >= MW'(TURN) <<< k) r = r - (MW'(TURN) <<< k);
            else if (r < -(MW'(TURN) <<< k)) r = r + (MW'(TURN) <<< k);
        end
        if (r < 0) r = r + MW'(TURN);
        if (r > MW'(HALF)) r = r - MW'(TURN);
        m1 = r;
    end
    cord_t c0;
    logic signed [MW-1:0] mf;
    logic nf;
    always_comb begin
        mf = m_reg;
        nf = 1'b0;
        if (m_reg > MW'(QUARTER)) begin
            mf = m_reg - MW'(HALF); nf = 1'b1;
        end else if (m_reg < -MW'(QUARTER)) begin
            mf = m_reg + MW'(HALF); nf = 1'b1;
        end
        c0.x = CORDIC_X0;
        c0.y = '0;
        c0.z = ZW'(mf) * 64'sd1000000000;
        c0.neg = nf;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_part;
            m_reg <= m1;
        end
    end
    cord_t chain [CORDIC_STEPS+1];
    cord_t c0_reg;
    always_ff @(posedge aclk) begin
        if (en) c0_reg <= c0;
    end
    assign chain[0] = c0_reg;
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        eypr_cell #(.STEP(i), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cell (
            .aclk(aclk), .en(en), .d_in(chain[i]), .d_out(chain[i+1])
        );
    end
    assign sin_q = chain[CORDIC_STEPS].neg ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
    assign cos_q = chain[CORDIC_STEPS].neg ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
endmodule
`default_nettype wire

// ===== rtl/core/eypr_matrix.sv =====
`default_nettype none
// Products of sines/cosines in three registered stages; the last one rounds and clamps.
module eypr_matrix #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [eypr_pkg::XW-1:0]       sy, cy, sp, cp, sr, cr,
    output logic [9*eypr_pkg::OUT_W-1:0]              mat
);
    import eypr_pkg::*;
    localparam int SH = WORK_BITS - OUT_FRAC_BITS;
    localparam logic signed [XW+1:0] ONE = (XW+2)'(1) <<< OUT_FRAC_BITS;

    function automatic logic signed [XW-1:0] qmul(input logic signed [XW-1:0] a,
                                                  input logic signed [XW-1:0] b);
        logic signed [2*XW-1:0] p;
        p = a * b + (2*XW)'(64'sd1 <<< (WORK_BITS-1));
        qmul = XW'(p >>> WORK_BITS);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [XW+1:0] q);
        logic signed [XW+1:0] v;
        v = (q + ((XW+2)'(1) <<< (SH-1))) >>> SH;
        if (v > ONE) v = ONE;
        if (v < -ONE) v = -ONE;
        to_out = v[OUT_W-1:0];
    endfunction

    logic signed [XW-1:0] cysp_reg, sysp_reg, sy1, cy1, sp1, cp1, sr1, cr1;
    logic signed [XW-1:0] a0, a1, a2, a3, a4, a5, a6, a7, a8, a9, a10, a11;
    logic signed [XW-1:0] sp2;
    logic [9*OUT_W-1:0] mat_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            cysp_reg <= qmul(cy, sp);
            sysp_reg <= qmul(sy, sp);
            sy1 <= sy; cy1 <= cy; sp1 <= sp; cp1 <= cp; sr1 <= sr; cr1 <= cr;
            a0 <= qmul(cy1, cp1);
            a1 <= qmul(cysp_reg, sr1);
            a2 <= qmul(sy1, cr1);
            a3 <= qmul(cysp_reg, cr1);
            a4 <= qmul(sy1, sr1);
            a5 <= qmul(sy1, cp1);
            a6 <= qmul(sysp_reg, sr1);
            a7 <= qmul(cy1, cr1);
            a8 <= qmul(sysp_reg, cr1);
            a9 <= qmul(cy1, sr1);
            a10 <= qmul(cp1, sr1);
            a11 <= qmul(cp1, cr1);
            sp2 <= sp1;
            mat_reg <= {to_out((XW+2)'(a11)), to_out((XW+2)'(a10)),
                        to_out(-(XW+2)'(sp2)),
                        to_out((XW+2)'(a8) - (XW+2)'(a9)),
                        to_out((XW+2)'(a6) + (XW+2)'(a7)),
                        to_out((XW+2)'(a5)),
                        to_out((XW+2)'(a3) + (XW+2)'(a4)),
                        to_out((XW+2)'(a1) - (XW+2)'(a2)),
                        to_out((XW+2)'(a0))};
        end
    end
    assign mat = mat_reg;
endmodule
`default_nettype wire

// ===== rtl/core/euler_ypr_to_rotation_matrix.sv =====
// Pipeline: input word to output word through 2 reduce stages, 1 seed,
//   28 CORDIC cells and 3 multiply/round stages.
// Throughput: one word per cycle; the whole pipe advances when the output
//   register is empty or being taken, so a stall freezes every stage.
// Reset: aresetn synchronous active low clears the valid pipe only.
`default_nettype none
module euler_ypr_to_rotation_matrix #(
    parameter int ANGLE_FRAC_BITS = eypr_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS   = eypr_pkg::OUT_FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // yaw_deg[17:0], pitch_deg[35:18], roll_deg[53:36], zero pad
    input  wire logic [55:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // r00[17:0] r01 r02 r10 r11 r12 r20 r21 r22[161:144], zero pad
    output logic [167:0]      m_tdata
);
    import eypr_pkg::*;
    localparam int LAT = 34;

    logic [LAT-1:0] vld_reg, vld_next;
    logic en;
    // pipe moves when the last stage is empty or drained
    assign en = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign vld_next = {vld_reg[LAT-2:0], s_tvalid};
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= vld_next;
    end

    logic signed [XW-1:0] sy, cy, sp, cp, sr, cr;
    eypr_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
        .aclk(aclk), .en(en), .ang(s_tdata[17:0]), .sin_q(sy), .cos_q(cy));
    eypr_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
        .aclk(aclk), .en(en), .ang(s_tdata[35:18]), .sin_q(sp), .cos_q(cp));
    eypr_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
        .aclk(aclk), .en(en), .ang(s_tdata[53:36]), .sin_q(sr), .cos_q(cr));

    logic [9*OUT_W-1:0] mat;
    eypr_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
        .aclk(aclk), .en(en), .sy(sy), .cy(cy), .sp(sp), .cp(cp),
        .sr(sr), .cr(cr), .mat(mat));

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {6'd0, mat};

    // a held output word is not lost
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped");
    // ready only blocks when output full
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("spurious backpressure");
endmodule
`default_nettype wire
